// File: rtl/mf3_pkg.sv
// ----------------------------------------------------------------------------
// mf3_pkg
// Shared types, register codes and compare helpers of the 3x3 median filter.
// ----------------------------------------------------------------------------
package mf3_pkg;

    // Pixel and window column types.
    typedef logic [7:0] pix_t;

    // One window column: two rows up, one row up, current row.
    typedef struct packed {
        pix_t a2;
        pix_t a1;
        pix_t p;
    } col_t;

    // One column after sorting its three pixels.
    typedef struct packed {
        pix_t lo;
        pix_t mid;
        pix_t hi;
    } sorted_t;

    // Window size and dimension limits.
    localparam int WIN        = 3;
    localparam int MIN_DIM    = 3;
    localparam int MAX_HEIGHT = 4096;
    localparam int CMP_W      = 14;

    // Configuration port geometry and register codes.
    localparam int ADDR_W = 3;
    localparam int DATA_W = 32;
    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    localparam logic [10:0] WIDTH_RESET  = 11'd640;
    localparam logic [12:0] HEIGHT_RESET = 13'd480;

    function automatic pix_t pmin(input pix_t a, input pix_t b);
        return (a < b) ? a : b;
    endfunction

    function automatic pix_t pmax(input pix_t a, input pix_t b);
        return (a < b) ? b : a;
    endfunction

    // Middle value of three.
    function automatic pix_t med3(input pix_t a, input pix_t b, input pix_t c);
        return pmax(pmin(a, b), pmin(pmax(a, b), c));
    endfunction

    function automatic sorted_t sort3(input col_t c);
        sorted_t s;
        s.lo  = pmin(pmin(c.a2, c.a1), c.p);
        s.mid = med3(c.a2, c.a1, c.p);
        s.hi  = pmax(pmax(c.a2, c.a1), c.p);
        return s;
    endfunction

endpackage

// File: rtl/median_filter_3x3_unit.sv
// ----------------------------------------------------------------------------
// median_filter_3x3_unit
// 3x3 median filter on a raster pixel stream, with line buffers in one
// synchronous memory and a pipelined median network.
// ----------------------------------------------------------------------------
//   channel   direction  handshake            payload
//   in        sink       in_valid / in_stall   func, pixel
//   out       source     out_valid / out_stall median, row_end, frame_end
//   cfg       APB slave  psel/penable/pready   paddr, pwdata, prdata
//
// One pixel is taken per clock when in_stall is low; the last pixel of a row
// holds the input while its two padded results leave the median pipeline.
// After reset a clearing pass writes zero to all MAX_WIDTH line memory
// entries, one per cycle, and no pixel is taken during it.
// A stalled output holds the whole pipeline; the input stalls in turn.
// ----------------------------------------------------------------------------
module median_filter_3x3_unit #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                       clk,
    input  logic                       rst_n,
    // Pixel input
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic                       func,
    input  logic [7:0]                 pixel,
    // Result output
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic [7:0]                 median,
    output logic                       row_end,
    output logic                       frame_end,
    // Configuration
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [mf3_pkg::ADDR_W-1:0] paddr,
    input  logic [mf3_pkg::DATA_W-1:0] pwdata,
    output logic [mf3_pkg::DATA_W-1:0] prdata,
    output logic                       pready
);
    import mf3_pkg::*;

    localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

    // Configuration registers
    logic [10:0]   width_reg;
    logic [12:0]   height_reg;
    logic          cfg_write;

    // Clearing pass
    logic          clr_active_reg;
    logic [AW-1:0] clr_addr_reg;

    // Frame counters and decoded position
    logic [AW-1:0] col_reg;
    logic [AW-1:0] col_next;
    logic [12:0]   row_reg;
    logic [12:0]   row_next;
    logic [CMP_W-1:0] w_lim;
    logic [CMP_W-1:0] h_lim;
    logic          last_col;
    logic          last_row;
    logic          active;
    pix_t          in_pix;
    logic          accept;

    // Line memory and its ports
    logic [15:0]   line_mem [MAX_WIDTH];
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [15:0]   mem_wdata;
    logic          fwd;
    logic [15:0]   rd_word_reg;

    // Stage 1: item waiting for its memory word
    logic          s1_valid_reg;
    logic [AW-1:0] s1_addr_reg;
    pix_t          s1_pix_reg;
    logic          s1_emit0_reg;
    logic          s1_tail_reg;
    logic          s1_last_row_reg;
    logic          s1_move;

    // Window and result expansion
    col_t          window_reg [WIN];
    logic          pend0_reg;
    logic          tail_reg;
    logic          step_reg;
    logic          tail_last_row_reg;
    logic [1:0]    npend;
    logic          issue;
    logic [1:0]    issue_off;
    logic          issue_row_end;
    logic          issue_frame_end;
    col_t          job_col [WIN];

    // Median pipeline
    logic          adv;
    logic          ja_valid_reg;
    col_t          ja_col_reg [WIN];
    logic          ja_row_end_reg;
    logic          ja_frame_end_reg;
    logic          jb_valid_reg;
    sorted_t       jb_sort_reg [WIN];
    logic          jb_row_end_reg;
    logic          jb_frame_end_reg;
    pix_t          lo_max;
    pix_t          mid_med;
    pix_t          hi_min;
    logic          out_valid_reg;
    pix_t          median_reg;
    logic          row_end_reg;
    logic          frame_end_reg;

    // ------------------------------------------------------------------
    // Configuration port
    // ------------------------------------------------------------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
        end
        else if (cfg_write)
        begin
            unique case (paddr[2])
                REG_WIDTH:  width_reg  <= pwdata[10:0];
                REG_HEIGHT: height_reg <= pwdata[12:0];
                default:    width_reg  <= width_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            REG_WIDTH:  prdata = {{(DATA_W-11){1'b0}}, width_reg};
            REG_HEIGHT: prdata = {{(DATA_W-13){1'b0}}, height_reg};
            default:    prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Effective frame size and position of the incoming pixel
    // ------------------------------------------------------------------
    always_comb
    begin
        w_lim = CMP_W'(width_reg);
        if (w_lim > CMP_W'(MAX_WIDTH))
            w_lim = CMP_W'(MAX_WIDTH);
        if (w_lim < CMP_W'(MIN_DIM))
            w_lim = CMP_W'(MIN_DIM);

        h_lim = CMP_W'(height_reg);
        if (h_lim > CMP_W'(MAX_HEIGHT))
            h_lim = CMP_W'(MAX_HEIGHT);
        if (h_lim < CMP_W'(MIN_DIM))
            h_lim = CMP_W'(MIN_DIM);
    end

    assign last_col = CMP_W'(col_reg) >= (w_lim - CMP_W'(1));
    assign last_row = CMP_W'(row_reg) >= (h_lim + CMP_W'(1));
    assign active   = row_reg >= 13'd2;
    // Flush positions and rows below the image feed zero pixels.
    assign in_pix   = (func || (CMP_W'(row_reg) >= h_lim)) ? '0 : pixel;

    assign col_next = last_col ? '0 : col_reg + AW'(1);
    assign row_next = last_col ? (last_row ? '0 : row_reg + 13'd1) : row_reg;

    // ------------------------------------------------------------------
    // Flow control
    // ------------------------------------------------------------------
    assign adv      = !out_valid_reg || !out_stall;
    assign npend    = 2'(pend0_reg) + (tail_reg ? (step_reg ? 2'd1 : 2'd2) : 2'd0);
    assign issue    = adv && (npend != 2'd0);
    assign s1_move  = s1_valid_reg && adv && (npend <= 2'd1);
    assign in_stall = clr_active_reg || (s1_valid_reg && !s1_move);
    assign accept   = in_valid && !in_stall;

    // ------------------------------------------------------------------
    // Counters and clearing pass
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg        <= '0;
            row_reg        <= '0;
            clr_active_reg <= 1'b1;
            clr_addr_reg   <= '0;
        end
        else
        begin
            if (accept)
            begin
                col_reg <= col_next;
                row_reg <= row_next;
            end
            if (clr_active_reg)
            begin
                clr_addr_reg <= clr_addr_reg + AW'(1);
                if (clr_addr_reg == AW'(MAX_WIDTH - 1))
                    clr_active_reg <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Line memory: write-back of {one row up, current} and read at accept
    // ------------------------------------------------------------------
    assign mem_we    = clr_active_reg || s1_move;
    assign mem_waddr = clr_active_reg ? clr_addr_reg : s1_addr_reg;
    assign mem_wdata = clr_active_reg ? 16'd0 : {rd_word_reg[7:0], s1_pix_reg};
    // A write in the same cycle to the column being read is forwarded.
    assign fwd       = s1_move && (s1_addr_reg == col_reg);

    always_ff @(posedge clk)
    begin
        if (mem_we)
            line_mem[mem_waddr] <= mem_wdata;
        if (accept)
            rd_word_reg <= fwd ? mem_wdata : line_mem[col_reg];
    end

    // ------------------------------------------------------------------
    // Stage 1 item
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (accept)
            s1_valid_reg <= 1'b1;
        else if (s1_move)
            s1_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_addr_reg     <= col_reg;
            s1_pix_reg      <= in_pix;
            s1_emit0_reg    <= active && (col_reg >= AW'(2));
            s1_tail_reg     <= active && last_col;
            s1_last_row_reg <= last_row;
        end
    end

    // ------------------------------------------------------------------
    // Window shift and pending results of the item in the window
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < WIN; i++)
                window_reg[i] <= '0;
            pend0_reg         <= 1'b0;
            tail_reg          <= 1'b0;
            step_reg          <= 1'b0;
            tail_last_row_reg <= 1'b0;
        end
        else
        begin
            if (s1_move)
            begin
                window_reg[0] <= window_reg[1];
                window_reg[1] <= window_reg[2];
                window_reg[2] <= '{a2: rd_word_reg[15:8], a1: rd_word_reg[7:0],
                                   p: s1_pix_reg};
                pend0_reg         <= s1_emit0_reg;
                tail_reg          <= s1_tail_reg;
                step_reg          <= 1'b0;
                tail_last_row_reg <= s1_last_row_reg;
            end
            else if (issue)
            begin
                priority if (pend0_reg)
                    pend0_reg <= 1'b0;
                else if (!step_reg)
                    step_reg <= 1'b1;
                else
                    tail_reg <= 1'b0;
            end
        end
    end

    // Select the columns of the next result; columns past the row are zero.
    assign issue_off       = pend0_reg ? 2'd0 : (step_reg ? 2'd2 : 2'd1);
    assign issue_row_end   = !pend0_reg && step_reg;
    assign issue_frame_end = issue_row_end && tail_last_row_reg;

    always_comb
    begin
        logic [2:0] sel;
        sel = '0;
        for (int j = 0; j < WIN; j++)
        begin
            sel        = 3'(issue_off) + 3'(j);
            job_col[j] = (sel < 3'(WIN)) ? window_reg[sel[1:0]] : '0;
        end
    end

    // ------------------------------------------------------------------
    // Median pipeline: column sort, then max of lows, median of middles,
    // min of highs and the median of those three.
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ja_valid_reg  <= 1'b0;
            jb_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            ja_valid_reg  <= issue;
            jb_valid_reg  <= ja_valid_reg;
            out_valid_reg <= jb_valid_reg;
        end
    end

    assign lo_max  = pmax(pmax(jb_sort_reg[0].lo, jb_sort_reg[1].lo), jb_sort_reg[2].lo);
    assign mid_med = med3(jb_sort_reg[0].mid, jb_sort_reg[1].mid, jb_sort_reg[2].mid);
    assign hi_min  = pmin(pmin(jb_sort_reg[0].hi, jb_sort_reg[1].hi), jb_sort_reg[2].hi);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int j = 0; j < WIN; j++)
            begin
                ja_col_reg[j]  <= job_col[j];
                jb_sort_reg[j] <= sort3(ja_col_reg[j]);
            end
            ja_row_end_reg   <= issue_row_end;
            ja_frame_end_reg <= issue_frame_end;
            jb_row_end_reg   <= ja_row_end_reg;
            jb_frame_end_reg <= ja_frame_end_reg;
            median_reg       <= med3(lo_max, mid_med, hi_min);
            row_end_reg      <= jb_row_end_reg;
            frame_end_reg    <= jb_frame_end_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign median    = median_reg;
    assign row_end   = row_end_reg;
    assign frame_end = frame_end_reg;

endmodule

// File: rtl/mf3_checker.sv
// ----------------------------------------------------------------------------
// mf3_checker
// Port-level checks of the 3x3 median filter, bound to its top level.
// ----------------------------------------------------------------------------
module mf3_checker (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       out_valid,
    input logic                       out_stall,
    input logic [7:0]                 median,
    input logic                       row_end,
    input logic                       frame_end,
    input logic                       psel,
    input logic                       penable,
    input logic                       pwrite,
    input logic [mf3_pkg::ADDR_W-1:0] paddr,
    input logic [mf3_pkg::DATA_W-1:0] pwdata,
    input logic [mf3_pkg::DATA_W-1:0] prdata,
    input logic                       pready
);
    import mf3_pkg::*;

    // A stalled result keeps its value.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(median)
            && $stable(row_end) && $stable(frame_end))
        else $error("result changed while stalled");

    // The last result of a frame also closes its row.
    a_frame_row: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && frame_end |-> row_end)
        else $error("frame end without row end");

    // A width write reads back on a read of that register that directly follows it.
    a_width_rb: assert property (@(posedge clk) disable iff (!rst_n)
        psel && penable && pwrite && pready && (paddr[2] == REG_WIDTH)
        ##1 psel && !pwrite && (paddr[2] == REG_WIDTH)
        |-> prdata[10:0] == $past(pwdata[10:0]))
        else $error("width readback mismatch");

    // A height write reads back on a read of that register that directly follows it.
    a_height_rb: assert property (@(posedge clk) disable iff (!rst_n)
        psel && penable && pwrite && pready && (paddr[2] == REG_HEIGHT)
        ##1 psel && !pwrite && (paddr[2] == REG_HEIGHT)
        |-> prdata[12:0] == $past(pwdata[12:0]))
        else $error("height readback mismatch");

endmodule

bind median_filter_3x3_unit mf3_checker u_mf3_checker (.*);

// File: test/median_filter_3x3_unit_tb.sv
// ----------------------------------------------------------------------------
// median_filter_3x3_unit_tb
// Self-checking bench for the 3x3 median filter. A scoreboard class mirrors
// the line memory, the window and the row and column counters. For every
// accepted pixel it works out the medians that pixel releases and checks the
// output transfers against them in order. Both channels idle at random. The
// image size is changed between phases, mid-frame too, across its full range.
// ----------------------------------------------------------------------------
module median_filter_3x3_unit_tb;
    import mf3_pkg::*;

    // One expected output transfer.
    typedef struct {
        pix_t median;
        bit   row_end;
        bit   frame_end;
    } filter_out_t;

    class median_scoreboard;
        localparam int LINE_DEPTH = 1024;
        localparam int MAX_PRINTS = 50;

        logic [10:0] width_reg;
        logic [12:0] height_reg;
        logic [15:0] line_mem [LINE_DEPTH];
        col_t        window [WIN];
        int unsigned col_idx;
        int unsigned row_idx;
        filter_out_t expected_results [$];
        int          error_count;

        function new();
            width_reg   = WIDTH_RESET;
            height_reg  = HEIGHT_RESET;
            col_idx     = 0;
            row_idx     = 0;
            error_count = 0;
            foreach (line_mem[i]) line_mem[i] = '0;
            foreach (window[i]) window[i] = '0;
        endfunction

        // Register update, as written over the configuration port.
        function void set_reg(logic idx, logic [31:0] value);
            if (idx == REG_WIDTH)
                width_reg = value[10:0];
            else
                height_reg = value[12:0];
        endfunction

        // Size in use, with out-of-range settings pulled into the legal range.
        function int unsigned eff_width();
            int unsigned w;
            w = width_reg;
            if (w < MIN_DIM) w = MIN_DIM;
            if (w > LINE_DEPTH) w = LINE_DEPTH;
            return w;
        endfunction

        function int unsigned eff_height();
            int unsigned h;
            h = height_reg;
            if (h < MIN_DIM) h = MIN_DIM;
            if (h > MAX_HEIGHT) h = MAX_HEIGHT;
            return h;
        endfunction

        function bit in_flush_rows();
            return row_idx >= eff_height();
        endfunction

        // Fifth smallest of the window columns from first_col on, zero beyond.
        function pix_t window_median(int unsigned first_col);
            pix_t        v [9];
            pix_t        key;
            int unsigned src;
            int          j;
            for (int k = 0; k < WIN; k++) begin
                src = first_col + k;
                v[3*k]     = (src < WIN) ? window[src].a2 : '0;
                v[3*k + 1] = (src < WIN) ? window[src].a1 : '0;
                v[3*k + 2] = (src < WIN) ? window[src].p  : '0;
            end
            for (int i = 1; i < 9; i++) begin
                key = v[i];
                j = i;
                while (j > 0 && v[j-1] > key) begin
                    v[j] = v[j-1];
                    j--;
                end
                v[j] = key;
            end
            return v[4];
        endfunction

        function void push_result(pix_t m, bit re, bit fe);
            filter_out_t r;
            r.median    = m;
            r.row_end   = re;
            r.frame_end = fe;
            expected_results.push_back(r);
        endfunction

        // Advance the filter state by one accepted pixel transfer.
        function void note_pixel(bit f, pix_t pix_in);
            int unsigned w, h, c;
            pix_t        p, up2, up1;
            logic [15:0] word;
            bit          last_col, last_row, active;
            w = eff_width();
            h = eff_height();
            p = (f || row_idx >= h) ? '0 : pix_in;
            c = col_idx;
            if (c >= LINE_DEPTH) c = LINE_DEPTH - 1;

            // Line memory keeps two rows per column: older byte high.
            word = line_mem[c];
            up2 = word[15:8];
            up1 = word[7:0];
            line_mem[c] = {up1, p};

            window[0] = window[1];
            window[1] = window[2];
            window[2].a2 = up2;
            window[2].a1 = up1;
            window[2].p  = p;

            last_col = (c >= w - 1);
            last_row = (row_idx >= h + 1);
            active   = (row_idx >= 2);

            if (active && c >= 2)
                push_result(window_median(0), 1'b0, 1'b0);
            if (active && last_col) begin
                push_result(window_median(1), 1'b0, 1'b0);
                push_result(window_median(2), 1'b1, last_row);
            end

            if (last_col) begin
                col_idx = 0;
                row_idx = last_row ? 0 : row_idx + 1;
            end else begin
                col_idx = c + 1;
            end
        endfunction

        function void report(string what, int exp_v, int act_v);
            error_count++;
            if (error_count <= MAX_PRINTS)
                $display("%0t: %s mismatch, expected %0d, actual %0d",
                         $time, what, exp_v, act_v);
        endfunction

        // Compare one output transfer with the oldest expectation.
        function void check_result(pix_t m, bit re, bit fe);
            filter_out_t r;
            if (expected_results.size() == 0) begin
                error_count++;
                if (error_count <= MAX_PRINTS)
                    $display("%0t: unexpected result, expected none, actual median %0d",
                             $time, m);
                return;
            end
            r = expected_results.pop_front();
            if (m !== r.median) report("median", r.median, m);
            if (re !== r.row_end) report("row_end", r.row_end, re);
            if (fe !== r.frame_end) report("frame_end", r.frame_end, fe);
        endfunction
    endclass

    localparam int LINE_DEPTH = 1024;
    localparam int SETTLE     = 20;
    localparam int IDLE_LIMIT = 4000;
    localparam int N_DIRECTED = 15;

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_stall;
    logic                func;
    logic [7:0]          pixel;
    logic                out_valid;
    logic                out_stall;
    logic [7:0]          median;
    logic                row_end;
    logic                frame_end;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [ADDR_W-1:0]   paddr;
    logic [DATA_W-1:0]   pwdata;
    logic [DATA_W-1:0]   prdata;
    logic                pready;

    median_scoreboard sb;
    int in_calm;
    int out_calm;
    int idle_cycles;

    // Directed frame on a 3x3 image: extremes, a flush marker inside the
    // image, and an image pixel inside the flush rows.
    bit   dir_func [N_DIRECTED] = '{0, 0, 0,  0, 0, 0,  1, 0, 0,
                                    1, 0, 1,  0, 1, 1};
    pix_t dir_pix  [N_DIRECTED] = '{8'd255, 8'd0, 8'd255,
                                    8'd0, 8'd255, 8'd128,
                                    8'd200, 8'd1, 8'd254,
                                    8'd0, 8'd255, 8'd77,
                                    8'd9, 8'd0, 8'd255};

    median_filter_3x3_unit #(
        .MAX_WIDTH (LINE_DEPTH)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .func      (func),
        .pixel     (pixel),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .median    (median),
        .row_end   (row_end),
        .frame_end (frame_end),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    // Clock generation.
    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Wait count for one transfer; now and then a calm stretch with no waits.
    function automatic int draw_wait(inout int calm_left);
        if (calm_left > 0) begin
            calm_left--;
            return 0;
        end
        if ($urandom_range(0, 19) == 0)
            calm_left = $urandom_range(8, 30);
        return $urandom_range(0, 9);
    endfunction

    // Pixel values lean toward extremes and near ties.
    function automatic pix_t pick_pixel();
        case ($urandom_range(0, 7))
            0:       return 8'd0;
            1:       return 8'd255;
            2, 3:    return pix_t'($urandom_range(100, 103));
            default: return pix_t'($urandom_range(0, 255));
        endcase
    endfunction

    // One register write: setup cycle, then access until pready.
    task automatic write_reg(input logic idx, input logic [12:0] value);
        logic [DATA_W-1:0] data;
        data = $urandom;
        if (idx == REG_WIDTH)
            data[10:0] = value[10:0];
        else
            data[12:0] = value;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (pready !== 1'b1);
        sb.set_reg(idx, data);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Offer one pixel after a random gap and hold it until the transfer.
    task automatic send_pixel(input bit f, input pix_t p);
        int gap;
        gap = draw_wait(in_calm);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        func     <= f;
        pixel    <= p;
        do @(posedge clk); while (in_stall !== 1'b0);
        sb.note_pixel(f, p);
    endtask

    // Random pixels; flush markers follow the row position, with some noise.
    task automatic feed_pixels(input int n);
        bit f;
        for (int i = 0; i < n; i++) begin
            f = sb.in_flush_rows();
            if ($urandom_range(0, 15) == 0)
                f = !f;
            send_pixel(f, pick_pixel());
        end
    endtask

    // Hold the input until every expected result is out and the pipe is empty.
    task automatic quiesce();
        in_valid <= 1'b0;
        while (sb.expected_results.size() != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic run_frames(input int w, input int h, input int frames);
        quiesce();
        write_reg(REG_WIDTH, 13'(w));
        write_reg(REG_HEIGHT, 13'(h));
        feed_pixels(frames * sb.eff_width() * (sb.eff_height() + 2));
    endtask

    // Output stall: a random hold after each result transfer.
    initial
    begin
        int stall_left;
        stall_left = 0;
        out_stall <= 1'b0;
        forever begin
            @(posedge clk);
            if (out_valid === 1'b1 && out_stall === 1'b0)
                stall_left = draw_wait(out_calm);
            if (stall_left > 0) begin
                out_stall <= 1'b1;
                stall_left--;
            end else begin
                out_stall <= 1'b0;
            end
        end
    end

    // Result checking.
    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0)
            sb.check_result(median, row_end, frame_end);
    end

    // Watchdog on cycles without any transfer.
    always @(posedge clk)
    begin
        if ((in_valid === 1'b1 && in_stall === 1'b0) ||
            (out_valid === 1'b1 && out_stall === 1'b0))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("[median_filter_3x3_unit] ERROR");
            $finish;
        end
    end

    // Main sequence.
    initial
    begin
        sb = new();
        in_calm     = 0;
        out_calm    = 0;
        idle_cycles = 0;
        rst_n    <= 1'b0;
        in_valid <= 1'b0;
        func     <= 1'b0;
        pixel    <= '0;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= '0;
        pwdata   <= '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed frame at the smallest size.
        write_reg(REG_WIDTH, 13'd3);
        write_reg(REG_HEIGHT, 13'd3);
        for (int i = 0; i < N_DIRECTED; i++)
            send_pixel(dir_func[i], dir_pix[i]);

        // Sizes below the legal range act as the minimum; then ordinary sizes.
        run_frames(0, 1, 2);
        run_frames(7, 5, 1);
        run_frames($urandom_range(3, 10), $urandom_range(3, 6), 1);
        run_frames($urandom_range(3, 10), $urandom_range(3, 6), 1);

        // Largest sizes, entered and left in the middle of a frame.
        quiesce();
        write_reg(REG_WIDTH, 13'd4);
        write_reg(REG_HEIGHT, 13'd8191);
        feed_pixels(14);
        quiesce();
        write_reg(REG_WIDTH, 13'd1024);
        feed_pixels(30);
        quiesce();
        write_reg(REG_WIDTH, 13'd2047);
        feed_pixels(10);
        quiesce();
        write_reg(REG_HEIGHT, 13'd4096);
        write_reg(REG_WIDTH, 13'd5);
        feed_pixels(12);
        quiesce();
        write_reg(REG_HEIGHT, 13'd4);
        feed_pixels(20);

        // Back to ordinary sizes.
        quiesce();
        write_reg(REG_WIDTH, 13'd12);
        write_reg(REG_HEIGHT, 13'd3);
        feed_pixels(40);
        run_frames($urandom_range(3, 9), $urandom_range(3, 5), 1);

        // Drain and finish.
        quiesce();
        if (sb.error_count == 0 && sb.expected_results.size() == 0) begin
            $display("[median_filter_3x3_unit] OK");
        end else begin
            $display("[median_filter_3x3_unit] ERROR");
        end
        $finish;
    end

endmodule
